// ===== sv/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Operation codes, character codes and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_SET  = 2'd2;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic ptr_clr;
        logic copy_rd;
        logic copy_wr;
        logic blank_wr;
        logic out_load;
    } tmcw_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic copy_last;
        logic blank_last;
    } tmcw_sts_t;

endpackage

// ===== sv/tmcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass, command execution, the scroll copy and the
// loading of the result register.
// ----------------------------------------------------------------------------
module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  tmcw_sts_t sts,
    output tmcw_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_EXEC    = 3'd2;
    localparam logic [2:0] ST_COPY_RD = 3'd3;
    localparam logic [2:0] ST_COPY_WR = 3'd4;
    localparam logic [2:0] ST_BLANK   = 3'd5;
    localparam logic [2:0] ST_RESP    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.blank_wr = 1'b1;
                if (sts.blank_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.scroll_req) begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_COPY_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_COPY_RD: begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd.copy_wr = 1'b1;
                state_next  = sts.copy_last ? ST_BLANK : ST_COPY_RD;
            end
            ST_BLANK: begin
                cmd.blank_wr = 1'b1;
                if (sts.blank_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/tmcw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the screen memory, the cursor, the sweep pointer and the result
// register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module tmcw_dp
    import tmcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  tmcw_cmd_t  cmd,
    output tmcw_sts_t  sts,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_char_code,
    input  logic [3:0] s_fg_color,
    input  logic [3:0] s_bg_color,
    input  logic [6:0] s_target_col,
    input  logic [5:0] s_target_row,
    output logic [6:0] m_cursor_col,
    output logic [4:0] m_cursor_row,
    output logic [10:0] m_cursor_position,
    output logic [7:0] m_cell_char,
    output logic [7:0] m_cell_attr,
    output logic       m_scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TBL_N  = 1 << COL_W;

    logic [15:0] mem [CELLS];
    logic [15:0] mem_q;

    logic [1:0]  mode_reg;
    logic [7:0]  ch_reg;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;
    logic [6:0]  tcol_reg;
    logic [5:0]  trow_reg;

    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic              scrolled_reg;
    logic              scrolled_next;

    logic [6:0]  out_col_reg;
    logic [4:0]  out_row_reg;
    logic [10:0] out_pos_reg;
    logic [7:0]  out_char_reg;
    logic [7:0]  out_attr_reg;
    logic        out_scr_reg;

    logic [COL_W-1:0]  tab_stop_tbl [TBL_N];
    logic              tab_ok_tbl [TBL_N];

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] tgt_addr;
    logic              tgt_in_range;
    logic              last_col;
    logic              last_row;
    logic              is_plain;
    logic              put_plain;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    for (genvar g = 0; g < TBL_N; g++) begin : g_tab
        assign tab_stop_tbl[g] = COL_W'(g + TAB_STOP - (g % TAB_STOP));
        assign tab_ok_tbl[g]   = (g + TAB_STOP < COLUMNS);
    end

    assign cur_addr = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign tgt_addr = ADDR_W'(trow_reg) * ADDR_W'(COLUMNS) + ADDR_W'(tcol_reg);
    assign tgt_in_range = ({1'b0, tcol_reg} < 8'(COLUMNS)) && ({1'b0, trow_reg} < 7'(ROWS));
    assign last_col = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign last_row = (cur_row_reg == ROW_W'(ROWS - 1));
    assign is_plain = (ch_reg != CH_LF) && (ch_reg != CH_TAB) && (ch_reg != CH_CR);
    assign put_plain = (mode_reg == MODE_PUT) && is_plain;

    assign sts.scroll_req = (mode_reg == MODE_PUT) && last_row
                            && ((ch_reg == CH_LF) || (is_plain && last_col));
    assign sts.copy_last  = (ptr_reg == ADDR_W'(CELLS - COLUMNS - 1));
    assign sts.blank_last = (ptr_reg == ADDR_W'(CELLS - 1));

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.exec) begin
            case (mode_reg)
                MODE_PUT: begin
                    case (ch_reg)
                        CH_LF: begin
                            cur_col_next = '0;
                            if (!last_row) begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                            end
                        end
                        CH_TAB: begin
                            if (tab_ok_tbl[cur_col_reg]) begin
                                cur_col_next = tab_stop_tbl[cur_col_reg];
                            end
                        end
                        CH_CR: begin
                            cur_col_next = '0;
                        end
                        default: begin
                            if (last_col) begin
                                cur_col_next = '0;
                                if (!last_row) begin
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                end
                            end else begin
                                cur_col_next = cur_col_reg + COL_W'(1);
                            end
                        end
                    endcase
                end
                MODE_SET: begin
                    if (tgt_in_range) begin
                        cur_col_next = COL_W'(tcol_reg);
                        cur_row_next = ROW_W'(trow_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clr) begin
            ptr_next = '0;
        end else if (cmd.copy_wr || cmd.blank_wr) begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
        rd_ok_next = rd_ok_reg;
        if (cmd.exec) begin
            rd_ok_next = (mode_reg == MODE_READ) && tgt_in_range;
        end
        scrolled_next = scrolled_reg;
        if (cmd.load_in) begin
            scrolled_next = 1'b0;
        end else if (cmd.exec && sts.scroll_req) begin
            scrolled_next = 1'b1;
        end
    end

    assign mem_we    = (cmd.exec && put_plain) || cmd.copy_wr || cmd.blank_wr;
    assign mem_waddr = cmd.exec ? cur_addr : ptr_reg;
    assign mem_wdata = cmd.exec ? {bg_reg, fg_reg, ch_reg} : (cmd.copy_wr ? mem_q : 16'd0);
    assign mem_re    = (cmd.exec && (mode_reg == MODE_READ) && tgt_in_range) || cmd.copy_rd;
    assign mem_raddr = cmd.copy_rd ? (ptr_reg + ADDR_W'(COLUMNS)) : tgt_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_mode;
            ch_reg   <= s_char_code;
            fg_reg   <= s_fg_color;
            bg_reg   <= s_bg_color;
            tcol_reg <= s_target_col;
            trow_reg <= s_target_row;
        end
        if (cmd.out_load) begin
            out_col_reg  <= 7'(cur_col_reg);
            out_row_reg  <= 5'(cur_row_reg);
            out_pos_reg  <= 11'(cur_addr);
            out_char_reg <= rd_ok_reg ? mem_q[7:0] : 8'd0;
            out_attr_reg <= rd_ok_reg ? mem_q[15:8] : 8'd0;
            out_scr_reg  <= scrolled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            ptr_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            scrolled_reg <= 1'b0;
        end else begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            ptr_reg      <= ptr_next;
            rd_ok_reg    <= rd_ok_next;
            scrolled_reg <= scrolled_next;
        end
    end

    assign m_cursor_col      = out_col_reg;
    assign m_cursor_row      = out_row_reg;
    assign m_cursor_position = out_pos_reg;
    assign m_cell_char       = out_char_reg;
    assign m_cell_attr       = out_attr_reg;
    assign m_scrolled        = out_scr_reg;

endmodule

// ===== sv/text_mode_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode console writer
// Character-cell screen with a cursor: puts characters, reads cells and
// moves the cursor, scrolling the screen up one line when needed.
//
//   Channel   Direction  Ports
//   s_        input      s_valid, s_ready, s_mode, s_char_code, s_fg_color,
//                        s_bg_color, s_target_col, s_target_row
//   m_        output     m_valid, m_ready, m_cursor_col, m_cursor_row,
//                        m_cursor_position, m_cell_char, m_cell_attr, m_scrolled
//
// A transaction without a scroll executes, then the result register is loaded
// at the same edge that accepts the next transaction.
// A scroll copies the screen memory up one row, one cell per read and write
// pair, then blanks the bottom row.
// After reset a clearing pass writes ROWS*COLUMNS cells, one per cycle, before
// s_ready rises. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_char_code,
    input  logic [3:0]  s_fg_color,
    input  logic [3:0]  s_bg_color,
    input  logic [6:0]  s_target_col,
    input  logic [5:0]  s_target_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cursor_col,
    output logic [4:0]  m_cursor_row,
    output logic [10:0] m_cursor_position,
    output logic [7:0]  m_cell_char,
    output logic [7:0]  m_cell_attr,
    output logic        m_scrolled
);

    tmcw_cmd_t cmd;
    tmcw_sts_t sts;

    tmcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tmcw_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_mode            (s_mode),
        .s_char_code       (s_char_code),
        .s_fg_color        (s_fg_color),
        .s_bg_color        (s_bg_color),
        .s_target_col      (s_target_col),
        .s_target_row      (s_target_row),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_position (m_cursor_position),
        .m_cell_char       (m_cell_char),
        .m_cell_attr       (m_cell_attr),
        .m_scrolled        (m_scrolled)
    );

endmodule
